/* rtl/stick_radial_dead_zone_unit_assert.svh */
// Assertion macros for the stick radial dead zone unit
`ifndef STICK_RADIAL_DEAD_ZONE_UNIT_ASSERT_SVH
`define STICK_RADIAL_DEAD_ZONE_UNIT_ASSERT_SVH

// Overlapping implication, aborted by reset
`define SRDZ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, live through reset
`define SRDZ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/srdz_pkg.sv */
// Shared types and constants for the stick radial dead zone unit
package srdz_pkg;

  localparam int RAW_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF = 12;
  localparam int AXIS_W        = 16;
  localparam int REG_W         = 15;
  localparam int QUO_W         = 16;
  localparam int IDX_W         = 1;

  localparam logic [REG_W-1:0]  DEAD_ZONE_RST = 15'd8000;
  localparam logic [REG_W-1:0]  MAX_AXIS_RST  = 15'd32767;
  localparam logic [REG_W-1:0]  LEVEL_MAX     = 15'd32767;
  localparam logic [QUO_W-1:0]  POS_LIMIT     = 16'd32767;
  localparam logic [QUO_W-1:0]  NEG_LIMIT     = 16'd32768;

  typedef enum logic [IDX_W-1:0] {
    REG_DEAD_ZONE = 1'b0,
    REG_MAX_AXIS  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] stick_x;
    logic signed [AXIS_W-1:0] stick_y;
    logic [REG_W-1:0]         trigger_raw;
  } sample_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] norm_x;
    logic signed [AXIS_W-1:0] norm_y;
    logic [REG_W-1:0]         trigger_level;
  } result_t;

endpackage

/* rtl/srdz_isqrt.sv */
// Pipelined integer square root, one root bit per stage
module srdz_isqrt #(
  parameter int RW    = 16,
  parameter int TAG_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [2*RW-1:0]   in_val,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [RW-1:0]     out_root,
  output logic [TAG_W-1:0]  out_tag
);

  localparam int SQ_W  = 2 * RW;
  localparam int RES_W = SQ_W + 1;

  logic             vld [RW];
  logic [SQ_W-1:0]  rem [RW];
  logic [RES_W-1:0] res [RW];
  logic [TAG_W-1:0] tag [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic             vld_in;
    logic [SQ_W-1:0]  rem_in;
    logic [RES_W-1:0] res_in;
    logic [TAG_W-1:0] tag_in;
    logic [RES_W-1:0] bit_w;
    logic [RES_W-1:0] trial;

    if (k == 0) begin : g_first
      assign vld_in = in_valid;
      assign rem_in = in_val;
      assign res_in = '0;
      assign tag_in = in_tag;
    end else begin : g_next
      assign vld_in = vld[k-1];
      assign rem_in = rem[k-1];
      assign res_in = res[k-1];
      assign tag_in = tag[k-1];
    end

    assign bit_w = RES_W'(1) << (2 * (RW - 1 - k));
    assign trial = res_in + bit_w;

    // take one root bit where the trial fits
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld_in;
      end
      tag[k] <= tag_in;
      if ({1'b0, rem_in} >= trial) begin
        rem[k] <= rem_in - trial[SQ_W-1:0];
        res[k] <= (res_in >> 1) + bit_w;
      end else begin
        rem[k] <= rem_in;
        res[k] <= res_in >> 1;
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign out_root  = res[RW-1][RW-1:0];
  assign out_tag   = tag[RW-1];

endmodule

/* rtl/srdz_div.sv */
// Pipelined restoring divider lanes with rounding and overflow detect
module srdz_div #(
  parameter int LANES = 3,
  parameter int NUM_W = 43,
  parameter int DEN_W = 30,
  parameter int Q_W   = 16,
  parameter int TAG_W = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [LANES-1:0][NUM_W-1:0]  in_num,
  input  logic [LANES-1:0][DEN_W-1:0]  in_den,
  input  logic [TAG_W-1:0]             in_tag,
  output logic                         out_valid,
  output logic [LANES-1:0][Q_W-1:0]    out_quo,
  output logic [LANES-1:0]             out_ovf,
  output logic [TAG_W-1:0]             out_tag
);

  localparam int W = (NUM_W + 1 > DEN_W + Q_W) ? NUM_W + 1 : DEN_W + Q_W;

  // rounding stage
  logic             pre_vld;
  logic [TAG_W-1:0] pre_tag;
  logic [W-1:0]     pre_rem [LANES];
  logic [DEN_W-1:0] pre_den [LANES];
  logic             pre_ovf [LANES];

  // quotient stages
  logic             vld [Q_W];
  logic [TAG_W-1:0] tag [Q_W];
  logic [W-1:0]     rem [Q_W][LANES];
  logic [DEN_W-1:0] den [Q_W][LANES];
  logic [Q_W-1:0]   quo [Q_W][LANES];
  logic             ovf [Q_W][LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_vld <= 1'b0;
    end else begin
      pre_vld <= in_valid;
    end
    pre_tag <= in_tag;
  end

  for (genvar l = 0; l < LANES; l++) begin : g_pre
    logic [W-1:0] rounded;
    assign rounded = W'(in_num[l]) + W'(in_den[l] >> 1);
    // add half the divisor and flag a quotient beyond range
    always_ff @(posedge clk) begin
      pre_rem[l] <= rounded;
      pre_den[l] <= in_den[l];
      pre_ovf[l] <= rounded >= (W'(in_den[l]) << Q_W);
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic             vld_in;
    logic [TAG_W-1:0] tag_in;

    if (k == 0) begin : g_first
      assign vld_in = pre_vld;
      assign tag_in = pre_tag;
    end else begin : g_next
      assign vld_in = vld[k-1];
      assign tag_in = tag[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld_in;
      end
      tag[k] <= tag_in;
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [W-1:0]     rem_in;
      logic [DEN_W-1:0] den_in;
      logic [Q_W-1:0]   quo_in;
      logic             ovf_in;
      logic [W-1:0]     trial;

      if (k == 0) begin : g_first
        assign rem_in = pre_rem[l];
        assign den_in = pre_den[l];
        assign quo_in = '0;
        assign ovf_in = pre_ovf[l];
      end else begin : g_next
        assign rem_in = rem[k-1][l];
        assign den_in = den[k-1][l];
        assign quo_in = quo[k-1][l];
        assign ovf_in = ovf[k-1][l];
      end

      assign trial = W'(den_in) << (Q_W - 1 - k);

      // subtract the shifted divisor where it fits
      always_ff @(posedge clk) begin
        den[k][l] <= den_in;
        ovf[k][l] <= ovf_in;
        if (rem_in >= trial) begin
          rem[k][l] <= rem_in - trial;
          quo[k][l] <= quo_in | (Q_W'(1) << (Q_W - 1 - k));
        end else begin
          rem[k][l] <= rem_in;
          quo[k][l] <= quo_in;
        end
      end

      if (k == Q_W - 1) begin : g_out
        assign out_quo[l] = quo[k][l];
        assign out_ovf[l] = ovf[k][l];
      end
    end
  end

  assign out_valid = vld[Q_W-1];
  assign out_tag   = tag[Q_W-1];

endmodule

/* rtl/stick_radial_dead_zone_unit.sv */
// Throughput: one item per cycle; start is taken in every cycle outside reset.
// Most depth is in the root stages (one per raw bit) and the divider (one per quotient bit).
// Results cannot be held off: each is shown for exactly one cycle on result_valid.
// Synchronous reset clears all valid bits and loads dead-zone radius 8000, full scale 32767.
// busy is high only during reset.
module stick_radial_dead_zone_unit #(
  parameter int RAW_WIDTH = srdz_pkg::RAW_WIDTH_DEF,
  parameter int FRAC_BITS = srdz_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  srdz_pkg::sample_t               sample,
  input  logic                            cfg_we,
  input  logic [srdz_pkg::IDX_W-1:0]      cfg_idx,
  input  logic [srdz_pkg::REG_W-1:0]      cfg_data,
  output logic                            result_valid,
  output srdz_pkg::result_t               result
);

  localparam int RW     = RAW_WIDTH;
  localparam int REG_W  = srdz_pkg::REG_W;
  localparam int QUO_W  = srdz_pkg::QUO_W;
  localparam int SQ_W   = 2 * RW;
  localparam int NUM_W  = RW + REG_W + FRAC_BITS;
  localparam int DEN_W  = 2 * REG_W;
  localparam int LANES  = 3;
  localparam int TAG_W  = 2 * RW + 2 + (RW - 1);
  localparam int CMP_W  = (RW > REG_W) ? RW : REG_W;
  localparam int LATENCY = RW + 23;

  // configuration registers
  logic [REG_W-1:0] dz_radius;
  logic [REG_W-1:0] max_axis;

  always_ff @(posedge clk) begin
    if (rst) begin
      dz_radius <= srdz_pkg::DEAD_ZONE_RST;
      max_axis  <= srdz_pkg::MAX_AXIS_RST;
    end else if (cfg_we) begin
      unique case (srdz_pkg::cfg_reg_t'(cfg_idx))
        srdz_pkg::REG_DEAD_ZONE: dz_radius <= cfg_data;
        srdz_pkg::REG_MAX_AXIS:  max_axis  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = rst;

  // stage 1: magnitudes and signs
  logic          s1_vld;
  logic [RW-1:0] s1_mag_x, s1_mag_y;
  logic          s1_neg_x, s1_neg_y;
  logic [RW-2:0] s1_trig;
  logic [RW-1:0] raw_x, raw_y;

  assign raw_x = sample.stick_x[RW-1:0];
  assign raw_y = sample.stick_y[RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start && !busy;
    end
    s1_neg_x <= raw_x[RW-1];
    s1_neg_y <= raw_y[RW-1];
    s1_mag_x <= raw_x[RW-1] ? (~raw_x + RW'(1)) : raw_x;
    s1_mag_y <= raw_y[RW-1] ? (~raw_y + RW'(1)) : raw_y;
    s1_trig  <= sample.trigger_raw[RW-2:0];
  end

  // stage 2: squares
  logic            s2_vld;
  logic [SQ_W-1:0] s2_sq_x, s2_sq_y;
  logic [TAG_W-1:0] s2_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_sq_x <= s1_mag_x * s1_mag_x;
    s2_sq_y <= s1_mag_y * s1_mag_y;
    s2_tag  <= {s1_mag_x, s1_mag_y, s1_neg_x, s1_neg_y, s1_trig};
  end

  // stage 3: sum of squares
  logic             s3_vld;
  logic [SQ_W-1:0]  s3_sum;
  logic [TAG_W-1:0] s3_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
    s3_sum <= s2_sq_x + s2_sq_y;
    s3_tag <= s2_tag;
  end

  // radius
  logic             rt_vld;
  logic [RW-1:0]    rt_root;
  logic [TAG_W-1:0] rt_tag;

  srdz_isqrt #(
    .RW    (RW),
    .TAG_W (TAG_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_vld),
    .in_val    (s3_sum),
    .in_tag    (s3_tag),
    .out_valid (rt_vld),
    .out_root  (rt_root),
    .out_tag   (rt_tag)
  );

  // clamp stage: limit radius, decide on the dead zone
  logic             cl_vld;
  logic [REG_W-1:0] cl_r;
  logic             cl_zero;
  logic [TAG_W-1:0] cl_tag;
  logic [REG_W-1:0] r_clamped;

  assign r_clamped = (CMP_W'(rt_root) > CMP_W'(max_axis)) ? max_axis : REG_W'(rt_root);

  always_ff @(posedge clk) begin
    if (rst) begin
      cl_vld <= 1'b0;
    end else begin
      cl_vld <= rt_vld;
    end
    cl_r    <= r_clamped;
    cl_zero <= (dz_radius >= max_axis) || (r_clamped < dz_radius) || (r_clamped == '0);
    cl_tag  <= rt_tag;
  end

  // product stage: numerators and divisors
  logic                         mu_vld;
  logic [LANES-1:0][NUM_W-1:0]  mu_num;
  logic [LANES-1:0][DEN_W-1:0]  mu_den;
  logic [2:0]                   mu_tag;
  logic [RW-1:0]                cl_mag_x, cl_mag_y;
  logic                         cl_neg_x, cl_neg_y;
  logic [RW-2:0]                cl_trig;
  logic [REG_W-1:0]             r_excess, span;
  logic [RW+REG_W-1:0]          prod_x, prod_y;

  assign {cl_mag_x, cl_mag_y, cl_neg_x, cl_neg_y, cl_trig} = cl_tag;
  assign r_excess = cl_r - dz_radius;
  assign span     = max_axis - dz_radius;
  assign prod_x   = cl_mag_x * r_excess;
  assign prod_y   = cl_mag_y * r_excess;

  always_ff @(posedge clk) begin
    if (rst) begin
      mu_vld <= 1'b0;
    end else begin
      mu_vld <= cl_vld;
    end
    mu_num[0] <= {prod_x, FRAC_BITS'(0)};
    mu_num[1] <= {prod_y, FRAC_BITS'(0)};
    mu_num[2] <= NUM_W'({cl_trig, FRAC_BITS'(0)});
    mu_den[0] <= span * cl_r;
    mu_den[1] <= span * cl_r;
    mu_den[2] <= DEN_W'(max_axis);
    mu_tag    <= {cl_neg_x, cl_neg_y, cl_zero};
  end

  // division lanes: x, y, trigger
  logic                       dv_vld;
  logic [LANES-1:0][QUO_W-1:0] dv_quo;
  logic [LANES-1:0]           dv_ovf;
  logic [2:0]                 dv_tag;

  srdz_div #(
    .LANES (LANES),
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (QUO_W),
    .TAG_W (3)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mu_vld),
    .in_num    (mu_num),
    .in_den    (mu_den),
    .in_tag    (mu_tag),
    .out_valid (dv_vld),
    .out_quo   (dv_quo),
    .out_ovf   (dv_ovf),
    .out_tag   (dv_tag)
  );

  // saturate and apply signs
  logic             dv_neg_x, dv_neg_y, dv_zero;
  logic [QUO_W-1:0] lim_x, lim_y, mag_x, mag_y;
  logic [REG_W-1:0] level;

  assign {dv_neg_x, dv_neg_y, dv_zero} = dv_tag;
  assign lim_x = dv_neg_x ? srdz_pkg::NEG_LIMIT : srdz_pkg::POS_LIMIT;
  assign lim_y = dv_neg_y ? srdz_pkg::NEG_LIMIT : srdz_pkg::POS_LIMIT;
  assign mag_x = (dv_ovf[0] || dv_quo[0] > lim_x) ? lim_x : dv_quo[0];
  assign mag_y = (dv_ovf[1] || dv_quo[1] > lim_y) ? lim_y : dv_quo[1];
  assign level = (dv_ovf[2] || dv_quo[2] > QUO_W'(srdz_pkg::LEVEL_MAX)) ?
                 srdz_pkg::LEVEL_MAX : dv_quo[2][REG_W-1:0];

  // output register, one strobe per item
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= dv_vld;
    end
    result.norm_x        <= dv_zero ? '0 : (dv_neg_x ? -mag_x : mag_x);
    result.norm_y        <= dv_zero ? '0 : (dv_neg_y ? -mag_y : mag_y);
    result.trigger_level <= level;
  end

endmodule

/* rtl/srdz_checker.sv */
// Port-level checks for the stick radial dead zone unit, bound to the top level
`include "stick_radial_dead_zone_unit_assert.svh"

module srdz_checker #(
  parameter int LAT = srdz_pkg::RAW_WIDTH_DEF + 23
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input srdz_pkg::sample_t sample,
  input logic              result_valid,
  input srdz_pkg::result_t result
);

  // every accepted item gives a strobe after the fixed latency
  `SRDZ_ASSERT_IMP(a_item_out, start && !busy, ##LAT result_valid, "accepted item lost")

  // no strobe without an item accepted that far back
  `SRDZ_ASSERT_IMP(a_no_invent, result_valid, $past(start && !busy, LAT), "result invented")

  // a centred horizontal axis gives zero
  `SRDZ_ASSERT_IMP(a_zero_x, result_valid && $past(sample.stick_x, LAT) == '0,
                   result.norm_x == '0, "zero axis gave nonzero output")

  // reset drops every item in flight
  `SRDZ_ASSERT_NXT(a_rst_clear, rst, !result_valid, "strobe right after reset")

endmodule

bind stick_radial_dead_zone_unit srdz_checker #(.LAT(LATENCY)) u_srdz_checker (.*);
